@@ hw/rtl/hds_pkg.sv @@
// Shared types and constants for the heat diffusion stencil step unit.
// Used by the front, queue, back and top level modules; no dependencies.
package hds_pkg;

    localparam int MAX_COLS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = $clog2(MAX_COLS + 1);
    localparam int DIV_W    = 16 + CNT_W;
    localparam int SUM_W    = 56;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_WEIGHT_DIRECT   = 3'd0,
        REG_WEIGHT_DIAGONAL = 3'd1,
        REG_THRESHOLD       = 3'd2,
        REG_ROWS_IN_USE     = 3'd3,
        REG_COLS_IN_USE     = 3'd4
    } t_reg_idx;

    // Row job handed from front to back
    typedef struct packed {
        logic [1:0]       up_slot;
        logic [1:0]       mid_slot;
        logic [1:0]       dn_slot;
        logic             kslot;
        logic [CNT_W-1:0] cols;
        logic             last;
        logic [DIV_W-1:0] divisor;
    } t_job;

    // Line store write command from front
    typedef struct packed {
        logic              en;
        logic [1:0]        slot;
        logic              kslot;
        logic [COL_W-1:0]  col;
        logic signed [31:0] temp;
        logic [16:0]       cond;
    } t_wr;

    // Per-item flags traveling down the back pipeline
    typedef struct packed {
        logic             produce;
        logic             eor;
        logic             eog;
        logic [1:0]       up_slot;
        logic [1:0]       mid_slot;
        logic [1:0]       dn_slot;
        logic             kslot;
        logic [DIV_W-1:0] divisor;
    } t_flags;

    // One column of the three-row window
    typedef struct packed {
        logic signed [31:0] up;
        logic signed [31:0] mid;
        logic signed [31:0] dn;
    } t_col;

    localparam logic signed [40:0] SAT_HI41 = 41'sd2147483647;
    localparam logic signed [40:0] SAT_LO41 = -41'sd2147483648;
    localparam logic [32:0]        MAX31_33 = 33'h07FFFFFFF;

endpackage

@@ hw/rtl/hds_queue.sv @@
// Two-entry job queue between front and back.
// Depends on hds_pkg for the job type.
module hds_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hds_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_empty,
    output hds_pkg::t_job o_job
);
    import hds_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push && r_cnt != 2'd2) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && r_cnt != 2'd2) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && r_cnt != 2'd0) begin
                r_rp <= ~r_rp;
            end
            case ({i_push && r_cnt != 2'd2, i_pop && r_cnt != 2'd0})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/hds_front.sv @@
// Front end: accepts cells, tracks row and column, writes the line store
// and queues a row job once a stream row past the first two closes. Depends on hds_pkg.
module hds_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [31:0]   i_temperature,
    input  logic [16:0]   i_conductivity,
    input  logic [15:0]   i_rows_in_use,
    input  logic [6:0]    i_cols_in_use,
    input  logic          i_back_busy,
    input  logic          i_q_empty,
    output hds_pkg::t_wr  o_wr,
    output logic          o_push,
    output hds_pkg::t_job o_job
);
    import hds_pkg::*;

    logic [CNT_W-1:0] r_col, n_col;
    logic [16:0]      r_row, n_row;
    logic [1:0]       r_slot, n_slot;
    logic [CNT_W-1:0] w_cols;
    logic [15:0]      w_rows;
    logic             w_acc, w_row_end, w_last;

    function automatic logic [1:0] slot_add(input logic [1:0] s, input logic [1:0] d);
        logic [2:0] t;
        t = {1'b0, s} + {1'b0, d};
        return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    endfunction

    // Clamp the geometry registers
    always_comb begin
        if (i_cols_in_use < 7'd3) begin
            w_cols = CNT_W'(3);
        end else if (i_cols_in_use > 7'(MAX_COLS)) begin
            w_cols = CNT_W'(MAX_COLS);
        end else begin
            w_cols = CNT_W'(i_cols_in_use);
        end
        w_rows = (i_rows_in_use == 16'd0) ? 16'd1 : i_rows_in_use;
    end

    assign o_ready   = !i_back_busy && i_q_empty;
    assign w_acc     = i_valid && o_ready;
    assign w_row_end = ({1'b0, r_col} + 1'b1) >= {1'b0, w_cols};
    assign w_last    = ({1'b0, r_row} + 18'd1) >= ({2'b0, w_rows} + 18'd2);

    // Line store write
    always_comb begin
        o_wr.en    = w_acc;
        o_wr.slot  = r_slot;
        o_wr.kslot = r_row[0];
        o_wr.col   = r_col[COL_W-1:0];
        o_wr.temp  = i_temperature;
        o_wr.cond  = i_conductivity;
    end

    // Row job for the back end
    always_comb begin
        o_push          = w_acc && w_row_end && (r_row >= 17'd2);
        o_job.up_slot   = slot_add(r_slot, 2'd1);
        o_job.mid_slot  = slot_add(r_slot, 2'd2);
        o_job.dn_slot   = r_slot;
        o_job.kslot     = ~r_row[0];
        o_job.cols      = w_cols;
        o_job.last      = w_last;
        o_job.divisor   = DIV_W'(w_rows) * DIV_W'(w_cols);
    end

    // Advance the raster position
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (w_acc) begin
            if (!w_row_end) begin
                n_col = r_col + 1'b1;
            end else begin
                n_col = '0;
                if (w_last) begin
                    n_row  = '0;
                    n_slot = 2'd0;
                end else begin
                    n_row  = r_row + 17'd1;
                    n_slot = slot_add(r_slot, 2'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= 2'd0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

endmodule

@@ hw/rtl/hds_back.sv @@
// Back end: holds the three-row line store, sweeps a queued row through
// the stencil pipeline, keeps sweep statistics and the output register.
// Depends on hds_pkg.
module hds_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hds_pkg::t_wr  i_wr,
    input  logic          i_job_valid,
    input  hds_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_rd_busy,
    input  logic [16:0]   i_weight_direct,
    input  logic [16:0]   i_weight_diagonal,
    input  logic [30:0]   i_threshold,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [159:0]  o_data,   // new_temperature, converged, min, max, max_diff, average
    output logic          o_last,   // end_of_row
    output logic          o_user    // end_of_grid
);
    import hds_pkg::*;

    // Line store: one memory per row slot, conductivity per row parity
    logic [31:0] r_mem0 [MAX_COLS];
    logic [31:0] r_mem1 [MAX_COLS];
    logic [31:0] r_mem2 [MAX_COLS];
    logic [16:0] r_memk0 [MAX_COLS];
    logic [16:0] r_memk1 [MAX_COLS];

    logic             r_rd_busy;
    logic [CNT_W:0]   r_i;
    t_job             r_job;
    logic             w_adv;
    logic [CNT_W:0]   w_addr_full;
    logic [COL_W-1:0] w_addr;

    logic [31:0]      r_d0, r_d1, r_d2;
    logic [16:0]      r_k0, r_k1;
    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    t_flags           r_f1, r_f2, r_f3, r_f4, r_f5, w_f0;

    t_col             r_wl, r_wm, r_wr, w_cnew;
    logic [16:0]      r_km, r_kr, w_knew;

    logic signed [51:0] r_pd, r_pg;
    logic signed [31:0] r_t3, r_t4, r_t5;
    logic [16:0]        r_k3, r_k4;
    logic signed [33:0] w_dsum, w_gsum;
    logic signed [52:0] w_acc;
    logic signed [36:0] w_s, r_s4, r_s5;
    logic signed [37:0] r_tms4;
    logic signed [55:0] r_prod5;
    logic signed [39:0] w_rk;
    logic signed [40:0] w_nv41;
    logic signed [31:0] w_nv;
    logic signed [32:0] w_diff;
    logic [32:0]        w_abs;
    logic [30:0]        w_d31;

    logic signed [31:0]       r_min, r_max, w_min_n, w_max_n;
    logic [30:0]              r_mdiff, w_mdiff_n;
    logic signed [SUM_W-1:0]  r_sum, w_sum_n;
    logic                     r_below, w_below_n;

    logic                     r_div_busy, r_div_done, r_neg;
    logic [5:0]               r_div_cnt;
    logic [DIV_W-1:0]         r_rem;
    logic [SUM_W-1:0]         r_quo;
    logic [DIV_W:0]           w_sh;
    logic                     w_ge;
    logic [SUM_W-1:0]         w_avg;

    logic                     r_o_valid, r_o_last, r_o_user;
    logic [159:0]             r_o_data;
    logic                     w_can_out, w_fire5;

    function automatic logic [31:0] pick3(input logic [1:0] s, input logic [31:0] a,
                                          input logic [31:0] b, input logic [31:0] c);
        logic [31:0] v;
        case (s)
            2'd0:    v = a;
            2'd1:    v = b;
            default: v = c;
        endcase
        return v;
    endfunction

    // Write cells from the front
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            case (i_wr.slot)
                2'd0:    r_mem0[i_wr.col] <= i_wr.temp;
                2'd1:    r_mem1[i_wr.col] <= i_wr.temp;
                default: r_mem2[i_wr.col] <= i_wr.temp;
            endcase
            if (i_wr.kslot) begin
                r_memk1[i_wr.col] <= i_wr.cond;
            end else begin
                r_memk0[i_wr.col] <= i_wr.cond;
            end
        end
    end

    // Read order: last column, then 0..cols-1, then column 0 again
    always_comb begin
        if (r_i == '0) begin
            w_addr_full = {1'b0, r_job.cols} - 1'b1;
        end else if (r_i <= {1'b0, r_job.cols}) begin
            w_addr_full = r_i - 1'b1;
        end else begin
            w_addr_full = '0;
        end
        w_addr = w_addr_full[COL_W-1:0];
        w_f0.produce  = (r_i >= (CNT_W+1)'(2));
        w_f0.eor      = (r_i == {1'b0, r_job.cols} + 1'b1);
        w_f0.eog      = w_f0.eor && r_job.last;
        w_f0.up_slot  = r_job.up_slot;
        w_f0.mid_slot = r_job.mid_slot;
        w_f0.dn_slot  = r_job.dn_slot;
        w_f0.kslot    = r_job.kslot;
        w_f0.divisor  = r_job.divisor;
    end

    assign o_job_pop = !r_rd_busy && i_job_valid;
    assign o_rd_busy = r_rd_busy;

    // Read sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_busy <= 1'b0;
            r_i       <= '0;
        end else if (o_job_pop) begin
            r_rd_busy <= 1'b1;
            r_i       <= '0;
        end else if (r_rd_busy && w_adv) begin
            r_i <= r_i + 1'b1;
            if (w_f0.eor) begin
                r_rd_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    // Registered memory reads
    always_ff @(posedge i_clk) begin
        if (w_adv && r_rd_busy) begin
            r_d0 <= r_mem0[w_addr];
            r_d1 <= r_mem1[w_addr];
            r_d2 <= r_mem2[w_addr];
            r_k0 <= r_memk0[w_addr];
            r_k1 <= r_memk1[w_addr];
        end
    end

    // Map slots onto window rows
    always_comb begin
        w_cnew.up  = pick3(r_f1.up_slot, r_d0, r_d1, r_d2);
        w_cnew.mid = pick3(r_f1.mid_slot, r_d0, r_d1, r_d2);
        w_cnew.dn  = pick3(r_f1.dn_slot, r_d0, r_d1, r_d2);
        w_knew     = r_f1.kslot ? r_k1 : r_k0;
    end

    // Stencil sums of the window
    always_comb begin
        w_dsum = 34'(r_wl.mid) + 34'(r_wr.mid) + 34'(r_wm.up) + 34'(r_wm.dn);
        w_gsum = 34'(r_wl.up) + 34'(r_wr.up) + 34'(r_wl.dn) + 34'(r_wr.dn);
        w_acc  = 53'(r_pd) + 53'(r_pg);
        w_s    = 37'((w_acc + 53'sd32768) >>> 16);
    end

    // Pipeline stages, all stepping together
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1 <= w_f0;
            if (r_v1) begin
                r_wl <= r_wm;
                r_wm <= r_wr;
                r_wr <= w_cnew;
                r_km <= r_kr;
                r_kr <= w_knew;
            end
            r_f2 <= r_f1;
            r_pd <= w_dsum * $signed({1'b0, i_weight_direct});
            r_pg <= w_gsum * $signed({1'b0, i_weight_diagonal});
            r_t3 <= r_wm.mid;
            r_k3 <= r_km;
            r_f3 <= r_f2;
            r_s4   <= 37'(w_s);
            r_t4   <= r_t3;
            r_k4   <= r_k3;
            r_tms4 <= 38'(r_t3) - 38'(w_s);
            r_f4   <= r_f3;
            r_prod5 <= $signed({1'b0, r_k4}) * r_tms4;
            r_s5    <= r_s4;
            r_t5    <= r_t4;
            r_f5    <= r_f4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= r_rd_busy;
            r_v2 <= r_v1 && r_f1.produce;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Final value, change and running statistics
    always_comb begin
        w_rk   = 40'((r_prod5 + 56'sd32768) >>> 16);
        w_nv41 = 41'(r_s5) + 41'(w_rk);
        if (w_nv41 > SAT_HI41) begin
            w_nv = 32'sh7FFFFFFF;
        end else if (w_nv41 < SAT_LO41) begin
            w_nv = 32'sh80000000;
        end else begin
            w_nv = w_nv41[31:0];
        end
        w_diff = 33'(w_nv) - 33'(r_t5);
        w_abs  = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
        w_d31  = (w_abs > MAX31_33) ? 31'h7FFFFFFF : w_abs[30:0];
        w_min_n   = (w_nv < r_min) ? w_nv : r_min;
        w_max_n   = (w_nv > r_max) ? w_nv : r_max;
        w_mdiff_n = (w_d31 > r_mdiff) ? w_d31 : r_mdiff;
        w_below_n = r_below && (w_d31 < i_threshold);
        w_sum_n   = r_sum + SUM_W'(w_nv);
    end

    assign w_can_out = !r_o_valid || i_ready;
    assign w_fire5   = r_v5 && w_can_out && (!r_f5.eog || r_div_done);
    assign w_adv     = !r_v5 || w_fire5;

    // Average divider, one quotient bit per cycle
    assign w_sh  = {r_rem, r_quo[SUM_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_f5.divisor};
    assign w_avg = r_neg ? SUM_W'(-r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_div_cnt  <= '0;
        end else if (r_v5 && r_f5.eog && !r_div_busy && !r_div_done) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + 6'd1;
            if (r_div_cnt == 6'(SUM_W - 1)) begin
                r_div_busy <= 1'b0;
                r_div_done <= 1'b1;
            end
        end else if (w_fire5 && r_f5.eog) begin
            r_div_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v5 && r_f5.eog && !r_div_busy && !r_div_done) begin
            r_rem <= '0;
            r_quo <= w_sum_n[SUM_W-1] ? SUM_W'(-w_sum_n) : SUM_W'(w_sum_n);
            r_neg <= w_sum_n[SUM_W-1];
        end else if (r_div_busy) begin
            r_rem <= w_ge ? DIV_W'(w_sh - {1'b0, r_f5.divisor}) : w_sh[DIV_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    // Hold statistics; drop them after the last result of a sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= 32'sh7FFFFFFF;
            r_max   <= 32'sh80000000;
            r_mdiff <= '0;
            r_sum   <= '0;
            r_below <= 1'b1;
        end else if (w_fire5) begin
            if (r_f5.eog) begin
                r_min   <= 32'sh7FFFFFFF;
                r_max   <= 32'sh80000000;
                r_mdiff <= '0;
                r_sum   <= '0;
                r_below <= 1'b1;
            end else begin
                r_min   <= w_min_n;
                r_max   <= w_max_n;
                r_mdiff <= w_mdiff_n;
                r_sum   <= w_sum_n;
                r_below <= w_below_n;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_fire5) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire5) begin
            r_o_last <= r_f5.eor;
            r_o_user <= r_f5.eog;
            if (r_f5.eog) begin
                r_o_data <= {w_avg[31:0], w_mdiff_n, w_max_n, w_min_n, w_below_n, w_nv};
            end else begin
                r_o_data <= {128'd0, w_nv};
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;
    assign o_user  = r_o_user;

endmodule

@@ hw/rtl/heat_diffusion_stencil_step_unit.sv @@
// Heat diffusion stencil step unit: cells stream in, one result per column of each row job out.
// The last result of a sweep also waits for the averaging divider. The input
// stalls while a row job is queued and while the back end reads the line store.
// Reset is synchronous, active low; registers return to defaults, counters and
// statistics clear; the line store is not cleared.
module heat_diffusion_stencil_step_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [55:0]  i_s_axis_tdata,   // temperature[31:0], conductivity[48:32]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [159:0] o_m_axis_tdata,   // new_temperature[31:0], converged[32],
                                           // min[64:33], max[96:65], max_diff[127:97],
                                           // average[159:128]
    output logic         o_m_axis_tlast,   // end_of_row
    output logic         o_m_axis_tuser,   // end_of_grid
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [4:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);
    import hds_pkg::*;

    logic [16:0] r_weight_direct, r_weight_diagonal;
    logic [30:0] r_threshold;
    logic [15:0] r_rows_in_use;
    logic [6:0]  r_cols_in_use;
    logic        w_wr_en;
    t_reg_idx    w_idx;

    t_wr  w_wr;
    t_job w_push_job, w_q_job;
    logic w_push, w_pop, w_q_valid, w_q_empty, w_rd_busy;

    assign o_pready = 1'b1;
    assign w_wr_en  = i_psel && i_penable && i_pwrite && o_pready;
    assign w_idx    = t_reg_idx'(i_paddr[4:2]);

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_direct   <= 17'd9598;
            r_weight_diagonal <= 17'd6786;
            r_threshold       <= 31'd6554;
            r_rows_in_use     <= 16'd64;
            r_cols_in_use     <= 7'd64;
        end else if (w_wr_en) begin
            unique case (w_idx)
                REG_WEIGHT_DIRECT:   r_weight_direct   <= i_pwdata[16:0];
                REG_WEIGHT_DIAGONAL: r_weight_diagonal <= i_pwdata[16:0];
                REG_THRESHOLD:       r_threshold       <= i_pwdata[30:0];
                REG_ROWS_IN_USE:     r_rows_in_use     <= i_pwdata[15:0];
                REG_COLS_IN_USE:     r_cols_in_use     <= i_pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (w_idx)
            REG_WEIGHT_DIRECT:   o_prdata = {15'd0, r_weight_direct};
            REG_WEIGHT_DIAGONAL: o_prdata = {15'd0, r_weight_diagonal};
            REG_THRESHOLD:       o_prdata = {1'b0, r_threshold};
            REG_ROWS_IN_USE:     o_prdata = {16'd0, r_rows_in_use};
            REG_COLS_IN_USE:     o_prdata = {25'd0, r_cols_in_use};
            default:             o_prdata = 32'd0;
        endcase
    end

    hds_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_temperature  (i_s_axis_tdata[31:0]),
        .i_conductivity (i_s_axis_tdata[48:32]),
        .i_rows_in_use  (r_rows_in_use),
        .i_cols_in_use  (r_cols_in_use),
        .i_back_busy    (w_rd_busy),
        .i_q_empty      (w_q_empty),
        .o_wr           (w_wr),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    hds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_empty (w_q_empty),
        .o_job   (w_q_job)
    );

    hds_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr              (w_wr),
        .i_job_valid       (w_q_valid),
        .i_job             (w_q_job),
        .o_job_pop         (w_pop),
        .o_rd_busy         (w_rd_busy),
        .i_weight_direct   (r_weight_direct),
        .i_weight_diagonal (r_weight_diagonal),
        .i_threshold       (r_threshold),
        .o_valid           (o_m_axis_tvalid),
        .i_ready           (i_m_axis_tready),
        .o_data            (o_m_axis_tdata),
        .o_last            (o_m_axis_tlast),
        .o_user            (o_m_axis_tuser)
    );

    // Never write the line store while the back end reads it
    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> !w_rd_busy)
        else $error("line store written during row read");

    // Summary fields stay zero off the last result of a sweep
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[159:32] == 128'd0))
        else $error("summary fields set on a non-final result");

    // A sweep ends only on a row end
    a_grid_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("end of grid without end of row");

endmodule
